// File: design/mdet_pkg.sv
// ----------------------------------------------------------------------------
// mdet_pkg
// Shared widths and constants of the matrix determinant block.
// ----------------------------------------------------------------------------
package mdet_pkg;
	localparam int DEF_MAX_DIM = 8;
	localparam int ELEM_W      = 16;
	localparam int DIM_W       = 4;
	localparam int RES_W       = 64;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam logic [APB_AW-1:0] ADDR_DIMENSION = 3'd0;
	localparam logic [DIM_W-1:0]  DIM_RESET      = 4'd1;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mdet_ctl_t;
endpackage

// File: design/mdet_if.sv
// ----------------------------------------------------------------------------
// mdet_in_if / mdet_out_if
// Valid/ready channels for matrix elements and determinant results.
// ----------------------------------------------------------------------------
interface mdet_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface mdet_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] determinant;
	logic               overflow;
	modport source (output valid, output determinant, output overflow, input ready);
	modport sink (input valid, input determinant, input overflow, output ready);
endinterface

// File: design/mdet_ram.sv
// ----------------------------------------------------------------------------
// mdet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdet_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/mdet_mac.sv
// ----------------------------------------------------------------------------
// mdet_mac
// Shared multiply-accumulate unit: acc +/- src * coeff over ACC_W bits.
// One 32-bit limb of the minor times the element magnitude per cycle while
// en is high, with product and sum carries held between limbs.
// ----------------------------------------------------------------------------
module mdet_mac #(
	parameter int ACC_W = 160
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               en,
	input  logic               neg,
	input  logic signed [15:0] coeff,
	input  logic [ACC_W-1:0]   src,
	input  logic [ACC_W-1:0]   acc_in,
	output logic [ACC_W-1:0]   acc_out,
	output logic               last
);
	localparam int NL = ACC_W / 32;
	localparam int LW = $clog2(NL);

	logic [LW-1:0] limb_q;
	logic [15:0]   pcy_q;
	logic          cy_q;
	logic [15:0]   mag;
	logic          sub;
	logic [31:0]   src_l;
	logic [31:0]   acc_l;
	logic [47:0]   prod;
	logic [32:0]   sum;

	always_comb begin
		mag   = coeff[15] ? (~coeff + 16'd1) : coeff;
		sub   = coeff[15] ^ neg;
		src_l = src[32*limb_q +: 32];
		acc_l = acc_in[32*limb_q +: 32];
		prod  = {16'b0, src_l} * {32'b0, mag} + {32'b0, pcy_q};
		if (sub) begin
			sum = {1'b0, acc_l} - {1'b0, prod[31:0]} - {32'b0, cy_q};
		end else begin
			sum = {1'b0, acc_l} + {1'b0, prod[31:0]} + {32'b0, cy_q};
		end
		acc_out = acc_in;
		acc_out[32*limb_q +: 32] = sum[31:0];
		last = (limb_q == LW'(NL - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limb_q <= '0;
			pcy_q  <= '0;
			cy_q   <= 1'b0;
		end else if (start) begin
			limb_q <= '0;
			pcy_q  <= '0;
			cy_q   <= 1'b0;
		end else if (en) begin
			limb_q <= last ? '0 : limb_q + 1'b1;
			pcy_q  <= prod[47:32];
			cy_q   <= sum[32];
		end
	end
endmodule

// File: design/matrix_determinant.sv
// ----------------------------------------------------------------------------
// matrix_determinant
// Exact determinant by cofactor expansion over column subsets.
// ----------------------------------------------------------------------------
// Usage: write dimension (byte address 0) over APB while idle; this restarts
// loading. Send n*n elements, row-major, on the input channel, one word per
// cycle. After the last word the block stops taking input and walks all
// column subsets through one shared limb-serial multiply-accumulate unit.
// Each product is a RAM read followed by a pass over the wide minor, one
// 32-bit limb at a time (NL = 5 limbs for MAX_DIM 8); each subset adds a
// column scan and write-back. The result word (saturated 64-bit determinant
// and overflow flag) moves to an output register and input reopens with it.
// A stalled receiver holds that word; a later result waits in write-back
// until it is taken. Reset clears dimension to 1, the load count and all
// control state.
// ----------------------------------------------------------------------------
module matrix_determinant #(
	parameter int MAX_DIM = mdet_pkg::DEF_MAX_DIM
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mdet_pkg::APB_AW-1:0] paddr,
	input  logic [mdet_pkg::APB_DW-1:0] pwdata,
	output logic [mdet_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	mdet_in_if.sink                     in_ch,
	mdet_out_if.source                  out_ch
);
	import mdet_pkg::*;

	localparam int NE    = MAX_DIM * MAX_DIM;
	localparam int EA_W  = $clog2(NE);
	localparam int NS    = 1 << MAX_DIM;
	localparam int SW    = MAX_DIM + 1;
	localparam int CW    = $clog2(MAX_DIM);
	localparam int ACC_W = ((MAX_DIM * 17 + 32) / 32) * 32;
	localparam int CNT_W = $clog2(NE + 1);

	typedef enum logic [2:0] {LOAD, SUB, COL, RD, ACC, DONE} st_t;

	st_t              st_q;
	logic [DIM_W-1:0] dim_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    s_q;
	logic [CW:0]      j_q;
	logic [CW:0]      pos_q;
	logic [ACC_W-1:0] acc_q;
	logic signed [RES_W-1:0] det_q;
	logic             ovf_q;
	logic             out_v_q;
	logic [DIM_W:0]   n;
	logic [CNT_W-1:0] total;
	logic             cfg_wr;
	logic             in_acc;
	logic             last_sub;
	logic             res_load;
	logic [ACC_W-1:0] acc_nx;
	logic             mac_last;
	logic [ACC_W-1:0] mrd;
	logic [15:0]      erd;
	logic [EA_W-1:0]  eaddr;
	logic [CW:0]      kbits;
	logic [CW:0]      row;
	logic [SW-1:0]    sub_s;
	mdet_ctl_t        ctl;

	assign pready = 1'b1;
	assign prdata = {{(APB_DW-DIM_W){1'b0}}, dim_q};
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_DIMENSION);

	always_comb begin
		if (dim_q == '0) n = (DIM_W+1)'(1);
		else if ({1'b0, dim_q} > (DIM_W+1)'(MAX_DIM)) n = (DIM_W+1)'(MAX_DIM);
		else n = {1'b0, dim_q};
		total = CNT_W'(n) * CNT_W'(n);
		kbits = '0;
		for (int b = 0; b < MAX_DIM; b++) begin
			if (b < n) kbits = kbits + (CW+1)'(s_q[b]);
		end
		row   = (CW+1)'(n) - kbits;
		eaddr = EA_W'(row) * EA_W'(n) + EA_W'(j_q);
		sub_s = s_q & ~(SW'(1) << j_q);
	end

	assign in_ch.ready = (st_q == LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign last_sub    = (s_q == (SW'(1) << n) - 1'b1);
	assign res_load    = (st_q == DONE) && last_sub && (!out_v_q || out_ch.ready);
	assign ctl.start   = in_acc && (cnt_q + 1'b1 == total);
	assign ctl.busy    = (st_q != LOAD);
	assign ctl.done    = out_v_q;

	mdet_ram #(.WIDTH(16), .DEPTH(NE)) u_elem (
		.clk(clk), .we(in_acc), .waddr(EA_W'(cnt_q)), .wdata(in_ch.element_value),
		.raddr(eaddr), .rdata(erd)
	);

	mdet_ram #(.WIDTH(ACC_W), .DEPTH(NS)) u_minor (
		.clk(clk), .we(st_q == DONE || st_q == SUB),
		.waddr(st_q == SUB ? '0 : MAX_DIM'(s_q)),
		.wdata(st_q == SUB ? ACC_W'(1) : acc_q),
		.raddr(MAX_DIM'(sub_s)), .rdata(mrd)
	);

	mdet_mac #(.ACC_W(ACC_W)) u_mac (
		.clk(clk), .arst_n(arst_n), .start(st_q == RD), .en(st_q == ACC),
		.neg(pos_q[0]), .coeff($signed(erd)), .src(mrd), .acc_in(acc_q),
		.acc_out(acc_nx), .last(mac_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= LOAD;
			dim_q   <= DIM_RESET;
			cnt_q   <= '0;
			s_q     <= '0;
			j_q     <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
			det_q   <= '0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				dim_q <= pwdata[DIM_W-1:0];
			end
			if (cfg_wr) begin
				cnt_q <= '0;
			end else if (in_acc) begin
				cnt_q <= ctl.start ? '0 : cnt_q + 1'b1;
			end
			if (res_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				LOAD: begin
					if (ctl.start) begin
						st_q <= SUB;
						s_q  <= '0;
					end
				end
				SUB: begin
					s_q   <= s_q + 1'b1;
					j_q   <= '0;
					pos_q <= '0;
					acc_q <= '0;
					st_q  <= COL;
				end
				COL: begin
					if (j_q == (CW+1)'(n)) begin
						st_q <= DONE;
					end else if (s_q[j_q]) begin
						st_q <= RD;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				RD: st_q <= ACC;
				ACC: begin
					acc_q <= acc_nx;
					if (mac_last) begin
						pos_q <= pos_q + 1'b1;
						j_q   <= j_q + 1'b1;
						st_q  <= COL;
					end
				end
				DONE: begin
					if (last_sub) begin
						if (res_load) begin
							if ((acc_q[ACC_W-1:RES_W-1] == '0) ||
								(acc_q[ACC_W-1:RES_W-1] == '1)) begin
								det_q <= acc_q[RES_W-1:0];
								ovf_q <= 1'b0;
							end else begin
								det_q <= acc_q[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}}
									: {1'b0, {(RES_W-1){1'b1}}};
								ovf_q <= 1'b1;
							end
							st_q <= LOAD;
						end
					end else begin
						s_q   <= s_q + 1'b1;
						j_q   <= '0;
						pos_q <= '0;
						acc_q <= '0;
						st_q  <= COL;
					end
				end
				default: st_q <= LOAD;
			endcase
		end
	end

	assign out_ch.valid       = ctl.done;
	assign out_ch.determinant = det_q;
	assign out_ch.overflow    = ovf_q;

	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.busy |-> !in_ch.ready) else $error("input open while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.determinant))
		else $error("result dropped");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> st_q == SUB) else $error("evaluation not started");
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix determinant block. Matrices of every
// dimension setting are loaded word by word; each determinant word is checked
// against a directed value or an exact wide-integer cofactor expansion, saturation flag included.
// ----------------------------------------------------------------------------
module testbench;
	import mdet_pkg::*;

	localparam int  MAXN       = DEF_MAX_DIM;
	localparam int  WIDE       = 192;
	localparam int  ITEM_GOAL  = 1400;
	localparam int  IDLE_WAIT  = 40;
	localparam longint LIMIT   = 2000000;
	localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

	typedef enum logic { ROW_DIM, ROW_ELEM } row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [31:0]       value;
		bit                typed;
		logic signed [63:0] det;
		bit                ovf;
	} stim_row_t;

	typedef struct {
		logic signed [63:0] det;
		bit                 ovf;
	} det_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	mdet_in_if  in_ch ();
	mdet_out_if out_ch ();

	matrix_determinant dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	logic [DIM_W-1:0]   dim_reg;
	logic signed [15:0] elem_mem [MAXN*MAXN];
	int                 fill_count;
	det_word_t          pending_dets [$];
	stim_row_t          rows [$];
	int                 mismatches;
	int                 items_sent;
	int                 burst_left;
	longint             cycles;
	int                 stall_mode;
	int                 stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.element_value = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
	end

	function automatic int active_dim();
		if (dim_reg == 0) return 1;
		if (dim_reg > MAXN) return MAXN;
		return int'(dim_reg);
	endfunction

	function automatic det_word_t expand_det(input int n);
		logic signed [WIDE-1:0] minor [1<<MAXN];
		logic signed [WIDE-1:0] acc, a, lim_hi, lim_lo;
		det_word_t r;
		int row, pos;
		minor[0] = 1;
		for (int s = 1; s < (1 << n); s++) begin
			row = n - $countones(s);
			acc = 0;
			pos = 0;
			for (int j = 0; j < n; j++) begin
				if (s[j]) begin
					a = elem_mem[row*n + j];
					if (pos % 2) acc = acc - a * minor[s & ~(1 << j)];
					else acc = acc + a * minor[s & ~(1 << j)];
					pos++;
				end
			end
			minor[s] = acc;
		end
		acc = minor[(1 << n) - 1];
		lim_hi = 64'sh7FFF_FFFF_FFFF_FFFF;
		lim_lo = -lim_hi - 1;
		if (acc > lim_hi) begin
			r.det = 64'sh7FFF_FFFF_FFFF_FFFF;
			r.ovf = 1'b1;
		end else if (acc < lim_lo) begin
			r.det = 64'sh8000_0000_0000_0000;
			r.ovf = 1'b1;
		end else begin
			r.det = acc[63:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic bit load_word(input logic signed [15:0] v, output det_word_t r);
		int n;
		n = active_dim();
		if (fill_count >= n*n) fill_count = 0;
		elem_mem[fill_count] = v;
		fill_count++;
		if (fill_count < n*n) return 1'b0;
		fill_count = 0;
		r = expand_det(n);
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input det_word_t exp_w,
		input logic signed [63:0] got_det, input logic got_ovf);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected det=%0d ovf=%0d, got det=%0d ovf=%0d",
				what, exp_w.det, exp_w.ovf, got_det, got_ovf);
	endtask

	// receiver: stall pattern of its own
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(5, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		det_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_dets.size() == 0) begin
				exp_w.det = 0;
				exp_w.ovf = 0;
				note_mismatch("unexpected word", exp_w, out_ch.determinant, out_ch.overflow);
			end else begin
				exp_w = pending_dets.pop_front();
				if (out_ch.determinant !== exp_w.det || out_ch.overflow !== exp_w.ovf)
					note_mismatch("determinant", exp_w, out_ch.determinant, out_ch.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_DIMENSION) begin
			dim_reg = data[DIM_W-1:0];
			fill_count = 0;
		end
	endtask

	task automatic apb_check_dim();
		det_word_t none;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_DIMENSION;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[DIM_W-1:0] !== dim_reg) begin
			none.det = 64'(dim_reg);
			none.ovf = 0;
			note_mismatch("dimension readback", none, 64'(prdata), 1'b0);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// called at a clock edge; drop valid there, then wait for every determinant
	task automatic set_dim(input logic [31:0] data);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		wait (pending_dets.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
		if ($urandom_range(0, 5) == 0) apb_write(ADDR_SPARE, $urandom);
		apb_write(ADDR_DIMENSION, data);
		apb_check_dim();
	endtask

	// called at a clock edge; returns on the edge that accepts the word
	task automatic send_word(input logic signed [15:0] v, input bit typed,
		input det_word_t typed_w);
		det_word_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.element_value <= v;
		do @(posedge clk); while (!in_ch.ready);
		if (load_word(v, r)) pending_dets.push_back(typed ? typed_w : r);
		items_sent++;
	endtask

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 6) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_row(input row_kind_t k, input logic [31:0] v,
		input bit t = 0, input logic signed [63:0] d = 0, input bit o = 0);
		stim_row_t r;
		r.kind = k;
		r.value = v;
		r.typed = t;
		r.det = d;
		r.ovf = o;
		rows.push_back(r);
	endtask

	task automatic run_directed();
		det_word_t tw;
		add_row(ROW_ELEM, 32'h0007, 1, 7);
		add_row(ROW_ELEM, 32'h8000, 1, -32768);
		add_row(ROW_ELEM, 32'h7FFF, 1, 32767);
		add_row(ROW_DIM, 0);
		add_row(ROW_ELEM, 32'hFFFF, 1, -1);
		add_row(ROW_DIM, 2);
		add_row(ROW_ELEM, 32'h7FFF);
		add_row(ROW_ELEM, 32'h8000);
		add_row(ROW_ELEM, 32'h8000);
		add_row(ROW_ELEM, 32'h7FFF);
		// scaled order-4 Hadamard: determinant past the signed 64-bit range
		add_row(ROW_DIM, 4);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				add_row(ROW_ELEM, ($countones(i & j) % 2) ? 32'h7FFF : 32'h8000);
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_DIM) begin
				set_dim(rows[i].value);
			end else begin
				tw.det = rows[i].det;
				tw.ovf = rows[i].ovf;
				send_word(rows[i].value[15:0], rows[i].typed, tw);
			end
		end
	endtask

	task automatic run_random();
		det_word_t none;
		int pick, n, mats;
		logic [31:0] d;
		none.det = 0;
		none.ovf = 0;
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) d = $urandom_range(8, 15);
			else if (pick < 10) d = $urandom_range(5, 7);
			else if (pick < 16) d = 0;
			else d = $urandom_range(1, 4);
			d[31:DIM_W] = (32-DIM_W)'($urandom);
			set_dim(d);
			n = active_dim();
			mats = (n >= 6) ? 1 : $urandom_range(1, 60 / (n*n) + 1);
			for (int m = 0; m < mats; m++)
				for (int e = 0; e < n*n; e++)
					send_word(rand_elem(), 0, none);
			// partial matrix, dropped by the next dimension write; for n = 1 a whole one
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, n*n - 1 + (n == 1))) send_word(rand_elem(), 0, none);
		end
	endtask

	initial begin
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		cycles = 0;
		stall_mode = 0;
		stall_left = 0;
		dim_reg = DIM_RESET;
		fill_count = 0;
		foreach (elem_mem[i]) elem_mem[i] = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		in_ch.valid <= 1'b0;
		wait (pending_dets.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
